/* rtl/core/rcc_pkg.sv */
package rcc_pkg;

	localparam int GAIN_TABLE_DEPTH = 256;
	localparam int IDX_W = $clog2(GAIN_TABLE_DEPTH);
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);

	localparam logic [63:0] Q30_ONE = 64'd1 << 30;
	localparam logic [63:0] PI_Q30 = 64'd3373259426;

	typedef enum logic [0:0] {
		REG_OVERLAP = 1'b0,
		REG_STEP    = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic signed [15:0] base_sample;
		logic signed [15:0] new_sample;
		logic               start_segment;
	} in_word_t;

	typedef struct packed {
		logic signed [15:0] mixed_sample;
		logic               in_overlap;
	} out_word_t;

	typedef struct packed {
		logic signed [15:0] base_sample;
		logic signed [15:0] new_sample;
		logic [IDX_W-1:0]   gain_idx;
		logic               in_overlap;
	} queue_word_t;

	typedef struct packed {
		logic [15:0] overlap_length;
		logic [15:0] phase_step;
	} cfg_t;

	typedef logic [16:0] rom_t [GAIN_TABLE_DEPTH];

	function automatic rom_t fade_rom_init();
		rom_t        rom;
		logic [63:0] a;
		logic [63:0] theta;
		logic [63:0] t2;
		logic [63:0] r;
		logic [63:0] x;
		logic [63:0] w;
		for (int i = 0; i < GAIN_TABLE_DEPTH; i++) begin
			if (2 * i <= GAIN_TABLE_DEPTH) begin
				a = 64'(i);
			end else begin
				a = 64'(GAIN_TABLE_DEPTH - i);
			end
			theta = (PI_Q30 * a) / GAIN_TABLE_DEPTH;
			t2 = (theta * theta) >> 30;
			r = Q30_ONE;
			x = ((t2 * r) >> 30) / 64'd90;
			r = (x >= Q30_ONE) ? 64'd0 : (Q30_ONE - x);
			x = ((t2 * r) >> 30) / 64'd56;
			r = (x >= Q30_ONE) ? 64'd0 : (Q30_ONE - x);
			x = ((t2 * r) >> 30) / 64'd30;
			r = (x >= Q30_ONE) ? 64'd0 : (Q30_ONE - x);
			x = ((t2 * r) >> 30) / 64'd12;
			r = (x >= Q30_ONE) ? 64'd0 : (Q30_ONE - x);
			x = ((t2 * r) >> 30) / 64'd2;
			r = (x >= Q30_ONE) ? 64'd0 : (Q30_ONE - x);
			if (2 * i <= GAIN_TABLE_DEPTH) begin
				w = (Q30_ONE + r + (64'd1 << 14)) >> 15;
			end else begin
				w = (Q30_ONE - r + (64'd1 << 14)) >> 15;
			end
			if (w > 64'd65536) begin
				w = 64'd65536;
			end
			rom[i] = w[16:0];
		end
		return rom;
	endfunction

	localparam rom_t FADE_ROM = fade_rom_init();

endpackage

/* rtl/core/rcc_front.sv */
module rcc_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  rcc_pkg::cfg_t        cfg,
	input  logic                 word_valid,
	input  rcc_pkg::in_word_t    word,
	input  logic                 queue_full,
	output logic                 push,
	output rcc_pkg::queue_word_t push_word
);
	import rcc_pkg::*;

	logic [15:0] count_q;
	logic [15:0] phase_q;
	logic [15:0] count_eff;
	logic [15:0] phase_eff;
	logic        hit;
	logic [31:0] phase_scaled;

	assign count_eff = word.start_segment ? 16'd0 : count_q;
	assign phase_eff = word.start_segment ? 16'd0 : phase_q;
	assign hit = count_eff < cfg.overlap_length;
	assign phase_scaled = {16'd0, phase_eff} * 32'(GAIN_TABLE_DEPTH);
	assign push = word_valid && !queue_full;

	always_comb begin
		push_word.base_sample = word.base_sample;
		push_word.new_sample = word.new_sample;
		push_word.gain_idx = phase_scaled[16 +: IDX_W];
		push_word.in_overlap = hit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			phase_q <= '0;
		end else if (push) begin
			if (hit) begin
				count_q <= count_eff + 16'd1;
				phase_q <= phase_eff + cfg.phase_step;
			end else begin
				count_q <= count_eff;
				phase_q <= phase_eff;
			end
		end
	end

endmodule

/* rtl/core/rcc_queue.sv */
module rcc_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  rcc_pkg::queue_word_t push_word,
	output logic                 full,
	input  logic                 pop,
	output rcc_pkg::queue_word_t head,
	output logic                 empty
);
	import rcc_pkg::*;

	queue_word_t         mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_q;
	logic [QPTR_W-1:0]   rd_q;
	logic [QPTR_W:0]     fill_q;

	assign full = fill_q == (QPTR_W + 1)'(QUEUE_DEPTH);
	assign empty = fill_q == '0;
	assign head = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			fill_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

/* rtl/core/rcc_back.sv */
module rcc_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  rcc_pkg::queue_word_t head,
	input  logic                 empty,
	output logic                 pop,
	output logic                 word_valid,
	input  logic                 word_stall,
	output rcc_pkg::out_word_t   word
);
	import rcc_pkg::*;

	logic [16:0]        w;
	logic [16:0]        w_in;
	logic [15:0]        gout;
	logic [15:0]        gin;

	logic               v_s1;
	logic [15:0]        gout_s1;
	logic [15:0]        gin_s1;
	logic signed [15:0] base_s1;
	logic signed [15:0] new_s1;
	logic               flag_s1;

	logic               v_s2;
	logic signed [32:0] pout_s2;
	logic signed [32:0] pin_s2;
	logic signed [15:0] new_s2;
	logic               flag_s2;

	logic               valid_q;
	out_word_t          word_q;

	logic               out_en;
	logic               s2_en;
	logic               s1_en;
	logic signed [33:0] sum;
	logic signed [17:0] rounded;
	logic signed [15:0] sat;

	assign out_en = !valid_q || !word_stall;
	assign s2_en = !v_s2 || out_en;
	assign s1_en = !v_s1 || s2_en;
	assign pop = s1_en && !empty;

	assign w = FADE_ROM[head.gain_idx];
	assign w_in = 17'd65536 - w;
	assign gout = w[16] ? 16'hffff : w[15:0];
	assign gin = w_in[16] ? 16'hffff : w_in[15:0];

	assign sum = 34'(pout_s2) + 34'(pin_s2) + 34'sd32768;
	assign rounded = sum[33:16];

	always_comb begin
		if (rounded > 18'sd32767) begin
			sat = 16'sh7fff;
		end else if (rounded < -18'sd32768) begin
			sat = -16'sh8000;
		end else begin
			sat = rounded[15:0];
		end
	end

	always_ff @(posedge clk) begin
		if (s1_en) begin
			gout_s1 <= gout;
			gin_s1 <= gin;
			base_s1 <= head.base_sample;
			new_s1 <= head.new_sample;
			flag_s1 <= head.in_overlap;
		end
		if (s2_en) begin
			pout_s2 <= base_s1 * $signed({1'b0, gout_s1});
			pin_s2 <= new_s1 * $signed({1'b0, gin_s1});
			new_s2 <= new_s1;
			flag_s2 <= flag_s1;
		end
		if (out_en) begin
			word_q.mixed_sample <= flag_s2 ? sat : new_s2;
			word_q.in_overlap <= flag_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			if (s1_en) begin
				v_s1 <= !empty;
			end
			if (s2_en) begin
				v_s2 <= v_s1;
			end
			if (out_en) begin
				valid_q <= v_s2;
			end
		end
	end

	assign word_valid = valid_q;
	assign word = word_q;

endmodule

/* rtl/core/raised_cosine_crossfade.sv */
// an accepted sample word passes through the queue, then the s1, s2 and output registers, to its mix word on the output
// throughput: one word per cycle, limited by the output handshake only
// a four-entry queue decouples the count/phase front from the gain and multiply back
// reset clears count, phase, queue and pipeline valids; overlap_length resets to 1
// and phase_step to 0
module raised_cosine_crossfade (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               sample_valid,
	output logic               sample_stall,
	input  rcc_pkg::in_word_t  sample_word,
	output logic               mix_valid,
	input  logic               mix_stall,
	output rcc_pkg::out_word_t mix_word
);
	import rcc_pkg::*;

	cfg_t        cfg_q;
	logic        q_push;
	queue_word_t q_push_word;
	logic        q_full;
	logic        q_pop;
	queue_word_t q_head;
	logic        q_empty;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_STEP) ? {16'd0, cfg_q.phase_step}
		: {16'd0, cfg_q.overlap_length};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.overlap_length <= 16'd1;
			cfg_q.phase_step <= 16'd0;
		end else if (psel && penable && pwrite && pready) begin
			case (paddr[2])
				REG_OVERLAP: cfg_q.overlap_length <= pwdata[15:0];
				REG_STEP: cfg_q.phase_step <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	assign sample_stall = q_full;

	rcc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.word_valid (sample_valid),
		.word       (sample_word),
		.queue_full (q_full),
		.push       (q_push),
		.push_word  (q_push_word)
	);

	rcc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_word (q_push_word),
		.full      (q_full),
		.pop       (q_pop),
		.head      (q_head),
		.empty     (q_empty)
	);

	rcc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (q_head),
		.empty      (q_empty),
		.pop        (q_pop),
		.word_valid (mix_valid),
		.word_stall (mix_stall),
		.word       (mix_word)
	);

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_full |-> !q_push)
		else $error("queue written while full");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_empty |-> !q_pop)
		else $error("queue read while empty");

	a_accept_fills: assert property (@(posedge clk) disable iff (!arst_n)
		(q_push && !q_pop) |=> !q_empty)
		else $error("accepted word lost from queue");

endmodule
